@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/sse_pkg.sv @@
// Types and constants for the SSE event parser
`default_nettype none
package sse_pkg;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_D = 8'h64;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_V = 8'h76;
  localparam logic [7:0] CH_N = 8'h6E;

  typedef enum logic [3:0] {
    ST_IDLE,     // collecting bytes
    ST_CRCHK,    // reading last kept byte of the line
    ST_HDR,      // reading header bytes one per cycle
    ST_DECIDE,   // classify line
    ST_COPY,     // copy line bytes into payload or type store
    ST_SEP,      // write separator newline
    ST_EMIT_T,   // emit type chunks
    ST_EMIT_D,   // emit data chunks
    ST_OUT       // hold a chunk until taken
  } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/sse_event_parser_core.sv @@
// SSE event parser: an ordinary byte is taken while idle and written to line RAM.
// A line feed stalls the input through the CR check, the header reads, decide and,
// for a data or event line, the copy (after a separator for a later data line).
// A blank line with a pending event dispatches it: type then data chunks of up to
// eight bytes are read out, each held until taken, with the input stalled.
// Synchronous active-low reset clears lengths and flags; RAM stays undefined until written.
`default_nettype none
`include "assert_macros.svh"
module sse_event_parser_core import sse_pkg::*; #(
  parameter int FIELD_CAP = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_part,
  output logic [63:0]      out_packed_bytes,
  output logic [3:0]       out_byte_count,
  output logic             out_last_of_part,
  output logic             out_last_of_event,
  output logic             out_overflow_seen
);
  localparam int LW = $clog2(FIELD_CAP);      // line/type address width
  localparam int PW = $clog2(2*FIELD_CAP);    // payload address width
  localparam int LC = LW + 1;                 // line/type count width
  localparam int PC = PW + 1;                 // payload count width

  state_t state_r, state_nxt;
  logic [LC-1:0] line_len_r, line_len_nxt;
  logic [LC-1:0] eff_len_r, eff_len_nxt;   // line length after CR strip
  logic [LC-1:0] type_len_r, type_len_nxt;
  logic [PC-1:0] pay_len_r, pay_len_nxt;
  logic has_pay_r, has_pay_nxt;
  logic ovf_r, ovf_nxt;
  logic [2:0] hidx_r, hidx_nxt;            // header byte index
  logic hdr_comment_r, hdr_comment_nxt;
  logic hdr_data_r, hdr_data_nxt;
  logic hdr_event_r, hdr_event_nxt;
  logic sp_data_r, sp_data_nxt;            // space at offset 5
  logic sp_event_r, sp_event_nxt;          // space at offset 6
  logic [LC-1:0] rd_r, rd_nxt;             // copy read pointer
  logic rd_pend_r, rd_pend_nxt;            // read issued last cycle
  logic to_type_r, to_type_nxt;
  logic [PC-1:0] epos_r, epos_nxt;         // emit position
  logic [3:0] ecnt_r, ecnt_nxt;            // bytes gathered in chunk
  logic [63:0] pk_r, pk_nxt;
  logic part_r, part_nxt;
  logic lop_r, lop_nxt, loe_r, loe_nxt;

  // RAM ports
  logic          l_we, t_we, p_we;
  logic [LW-1:0] l_wa, l_ra, t_wa, t_ra;
  logic [PW-1:0] p_wa, p_ra;
  logic [7:0]    l_wd, t_wd, p_wd, l_rd, t_rd, p_rd;

  sse_mem #(.Depth(FIELD_CAP))   u_line (.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd),
                                         .raddr(l_ra), .rdata(l_rd));
  sse_mem #(.Depth(FIELD_CAP))   u_type (.clk, .we(t_we), .waddr(t_wa), .wdata(t_wd),
                                         .raddr(t_ra), .rdata(t_rd));
  sse_mem #(.Depth(2*FIELD_CAP)) u_pay  (.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd),
                                         .raddr(p_ra), .rdata(p_rd));

  logic acc_in, acc_out;
  assign in_stall = (state_r != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT);
  assign acc_out  = out_valid && !out_stall;
  assign out_part = part_r;
  assign out_packed_bytes = pk_r;
  assign out_byte_count = ecnt_r;
  assign out_last_of_part = lop_r;
  assign out_last_of_event = loe_r;
  assign out_overflow_seen = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      line_len_r <= '0;
      type_len_r <= '0;
      pay_len_r <= '0;
      has_pay_r <= 1'b0;
      ovf_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      line_len_r <= line_len_nxt;
      type_len_r <= type_len_nxt;
      pay_len_r <= pay_len_nxt;
      has_pay_r <= has_pay_nxt;
      ovf_r <= ovf_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    eff_len_r <= eff_len_nxt;
    hidx_r <= hidx_nxt;
    hdr_comment_r <= hdr_comment_nxt;
    hdr_data_r <= hdr_data_nxt;
    hdr_event_r <= hdr_event_nxt;
    sp_data_r <= sp_data_nxt;
    sp_event_r <= sp_event_nxt;
    rd_r <= rd_nxt;
    to_type_r <= to_type_nxt;
    epos_r <= epos_nxt;
    ecnt_r <= ecnt_nxt;
    pk_r <= pk_nxt;
    part_r <= part_nxt;
    lop_r <= lop_nxt;
    loe_r <= loe_nxt;
  end

  // expected header byte at index i
  function automatic logic [7:0] data_ch(input logic [2:0] i);
    case (i)
      3'd0: data_ch = CH_D;
      3'd1: data_ch = CH_A;
      3'd2: data_ch = CH_T;
      3'd3: data_ch = CH_A;
      3'd4: data_ch = CH_COLON;
      default: data_ch = CH_SPACE;
    endcase
  endfunction
  function automatic logic [7:0] event_ch(input logic [2:0] i);
    case (i)
      3'd0: event_ch = CH_E;
      3'd1: event_ch = CH_V;
      3'd2: event_ch = CH_E;
      3'd3: event_ch = CH_N;
      3'd4: event_ch = CH_T;
      3'd5: event_ch = CH_COLON;
      default: event_ch = CH_SPACE;
    endcase
  endfunction

  logic [2:0] hprev;
  logic [LC-1:0] cur_len, tlen_lim;
  logic [PC-1:0] elen;
  logic [7:0] rbyte;

  always_comb begin
    state_nxt = state_r;
    line_len_nxt = line_len_r;
    eff_len_nxt = eff_len_r;
    type_len_nxt = type_len_r;
    pay_len_nxt = pay_len_r;
    has_pay_nxt = has_pay_r;
    ovf_nxt = ovf_r;
    hidx_nxt = hidx_r;
    hdr_comment_nxt = hdr_comment_r;
    hdr_data_nxt = hdr_data_r;
    hdr_event_nxt = hdr_event_r;
    sp_data_nxt = sp_data_r;
    sp_event_nxt = sp_event_r;
    rd_nxt = rd_r;
    rd_pend_nxt = 1'b0;
    to_type_nxt = to_type_r;
    epos_nxt = epos_r;
    ecnt_nxt = ecnt_r;
    pk_nxt = pk_r;
    part_nxt = part_r;
    lop_nxt = lop_r;
    loe_nxt = loe_r;
    l_we = 1'b0; l_wa = line_len_r[LW-1:0]; l_wd = in_byte_in;
    l_ra = '0;
    t_we = 1'b0; t_wa = type_len_r[LW-1:0]; t_wd = l_rd; t_ra = epos_r[LW-1:0];
    p_we = 1'b0; p_wa = pay_len_r[PW-1:0]; p_wd = l_rd; p_ra = epos_r[PW-1:0];
    hprev = hidx_r - 3'd1;
    cur_len = '0;
    tlen_lim = '0;
    elen = '0;
    rbyte = part_r ? p_rd : t_rd;

    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (in_byte_in == CH_LF) begin
            l_ra = line_len_r[LW-1:0] - 1'b1;
            state_nxt = ST_CRCHK;
          end else if (line_len_r < LC'(FIELD_CAP)) begin
            l_we = 1'b1;
            line_len_nxt = line_len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_CRCHK: begin
        cur_len = line_len_r;
        if (line_len_r != '0 && l_rd == CH_CR) cur_len = line_len_r - 1'b1;
        eff_len_nxt = cur_len;
        hidx_nxt = 3'd0;
        hdr_comment_nxt = 1'b0;
        hdr_data_nxt = (cur_len >= LC'(5));
        hdr_event_nxt = (cur_len >= LC'(6));
        sp_data_nxt = (cur_len > LC'(5));
        sp_event_nxt = (cur_len > LC'(6));
        l_ra = '0;
        if (cur_len == '0) begin
          line_len_nxt = '0;
          if (!has_pay_r && type_len_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            part_nxt = 1'b0;
            epos_nxt = '0;
            ecnt_nxt = '0;
            pk_nxt = '0;
            // first type byte is read now, valid in the first emit cycle
            t_ra = '0;
            rd_pend_nxt = 1'b1;
            state_nxt = ST_EMIT_T;
          end
        end else begin
          hidx_nxt = 3'd1;
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        // l_rd holds byte hidx_r-1; issue next read
        l_ra = LW'(hidx_r);
        if (hprev == 3'd0) hdr_comment_nxt = (l_rd == CH_COLON);
        if (hprev < 3'd5 && l_rd != data_ch(hprev)) hdr_data_nxt = 1'b0;
        if (hprev == 3'd5 && l_rd != CH_SPACE) sp_data_nxt = 1'b0;
        if (hprev < 3'd6 && l_rd != event_ch(hprev)) hdr_event_nxt = 1'b0;
        if (hprev == 3'd6 && l_rd != CH_SPACE) sp_event_nxt = 1'b0;
        if (hprev == 3'd6 || LC'(hidx_r) >= eff_len_r) state_nxt = ST_DECIDE;
        else hidx_nxt = hidx_r + 3'd1;
      end
      ST_DECIDE: begin
        line_len_nxt = '0;
        state_nxt = ST_IDLE;
        if (!hdr_comment_r) begin
          if (hdr_data_r) begin
            has_pay_nxt = 1'b1;
            if (pay_len_r < PC'(FIELD_CAP)) begin
              to_type_nxt = 1'b0;
              rd_nxt = sp_data_r ? LC'(6) : LC'(5);
              state_nxt = has_pay_r ? ST_SEP : ST_COPY;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (hdr_event_r) begin
            to_type_nxt = 1'b1;
            type_len_nxt = '0;
            rd_nxt = sp_event_r ? LC'(7) : LC'(6);
            state_nxt = ST_COPY;
          end
        end
      end
      ST_SEP: begin
        p_we = 1'b1;
        p_wd = CH_LF;
        pay_len_nxt = pay_len_r + 1'b1;
        state_nxt = ST_COPY;
      end
      ST_COPY: begin
        // issue read of rd_r, write byte read last cycle
        l_ra = rd_r[LW-1:0];
        tlen_lim = type_len_r;
        if (rd_pend_r) begin
          if (to_type_r) begin
            if (type_len_r < LC'(FIELD_CAP)) begin
              t_we = 1'b1;
              type_len_nxt = type_len_r + 1'b1;
              tlen_lim = type_len_r + 1'b1;
            end
          end else if (pay_len_r < PC'(2*FIELD_CAP)) begin
            p_we = 1'b1;
            pay_len_nxt = pay_len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (rd_r < eff_len_r && !(to_type_r && tlen_lim >= LC'(FIELD_CAP))) begin
          rd_pend_nxt = 1'b1;
          rd_nxt = rd_r + 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt = ST_IDLE;
        end
        // a pending write this cycle with nothing issued ends next cycle
        if (rd_pend_r && !rd_pend_nxt) state_nxt = ST_IDLE;
      end
      ST_EMIT_T, ST_EMIT_D: begin
        // rd_pend_r: read data of epos_r is valid now
        elen = part_r ? pay_len_r : PC'(type_len_r);
        t_ra = epos_r[LW-1:0];
        p_ra = epos_r[PW-1:0];
        if (epos_r >= elen) begin
          // string finished
          lop_nxt = 1'b1;
          loe_nxt = part_r;
          state_nxt = ST_OUT;
        end else if (!rd_pend_r) begin
          rd_pend_nxt = 1'b1;
        end else begin
          pk_nxt = pk_r | (64'(rbyte) << {ecnt_r[2:0], 3'b000});
          ecnt_nxt = ecnt_r + 4'd1;
          epos_nxt = epos_r + 1'b1;
          if (ecnt_r == 4'd7 || epos_r + 1'b1 >= elen) begin
            lop_nxt = (epos_r + 1'b1 >= elen);
            loe_nxt = part_r && (epos_r + 1'b1 >= elen);
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (acc_out) begin
          ecnt_nxt = '0;
          pk_nxt = '0;
          if (!lop_r) begin
            state_nxt = part_r ? ST_EMIT_D : ST_EMIT_T;
          end else if (!part_r) begin
            part_nxt = 1'b1;
            epos_nxt = '0;
            lop_nxt = 1'b0;
            state_nxt = ST_EMIT_D;
          end else begin
            pay_len_nxt = '0;
            type_len_nxt = '0;
            has_pay_nxt = 1'b0;
            lop_nxt = 1'b0;
            loe_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_len_cap, clk, rst_n, 1'b1, line_len_r <= LC'(FIELD_CAP))
  `ASSERT_IMPL(a_cnt_max, clk, rst_n, out_valid, out_byte_count <= 4'd8)
  `ASSERT_IMPL(a_loe_lop, clk, rst_n, out_valid && out_last_of_event, out_last_of_part)
  `ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_r, ovf_r)
endmodule
`default_nettype wire

@@ hw/rtl/sse_mem.sv @@
// Simple dual-port synchronous RAM (one write port, one read port), registered read
`default_nettype none
module sse_mem #(
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [7:0]               wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [7:0]               rdata
);
  logic [7:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the SSE event parser core
`default_nettype none

class chunk_scoreboard;
  typedef struct packed {
    logic        part;
    logic [63:0] packed_bytes;
    logic [3:0]  byte_count;
    logic        last_of_part;
    logic        last_of_event;
    logic        overflow_seen;
  } chunk_t;

  localparam int CAP = 64;

  // parser state mirror
  byte unsigned line_buf[CAP];
  int unsigned  line_len;
  byte unsigned pay_buf[2*CAP];
  int unsigned  pay_len;
  byte unsigned type_buf[CAP];
  int unsigned  type_len;
  bit           got_data;
  bit           ovf;

  chunk_t pending[$];
  int     errors;
  int     chunks_seen;
  int     events_seen;

  function void clear();
    line_len = 0; pay_len = 0; type_len = 0; got_data = 0; ovf = 0;
    pending.delete();
    errors = 0; chunks_seen = 0; events_seen = 0;
  endfunction

  // split a string into chunks of up to 8 bytes (one empty chunk for an empty string)
  function void queue_chunks(bit which, int unsigned len, bit ends_event);
    int unsigned pos;
    int unsigned n;
    chunk_t c;
    pos = 0;
    do begin
      n = len - pos;
      if (n > 8) n = 8;
      c = '0;
      c.part = which;
      for (int i = 0; i < n; i++)
        c.packed_bytes[8*i +: 8] = which ? pay_buf[pos+i] : type_buf[pos+i];
      pos += n;
      c.byte_count = n[3:0];
      c.last_of_part = (pos >= len);
      c.last_of_event = (pos >= len) && ends_event;
      c.overflow_seen = ovf;
      pending.push_back(c);
    end while (pos < len);
  endfunction

  function bit line_has(string tag);
    if (line_len < tag.len()) return 0;
    for (int i = 0; i < tag.len(); i++)
      if (line_buf[i] != tag[i]) return 0;
    return 1;
  endfunction

  function void add_payload(byte unsigned b);
    if (pay_len < 2*CAP) begin
      pay_buf[pay_len] = b;
      pay_len++;
    end else ovf = 1;
  endfunction

  function void end_line();
    int unsigned len;
    int unsigned off;
    len = line_len;
    if (len > 0 && line_buf[len-1] == sse_pkg::CH_CR) len--;
    if (len == 0) begin
      if (!got_data && type_len == 0) return;
      queue_chunks(1'b0, type_len, 1'b0);
      queue_chunks(1'b1, pay_len, 1'b1);
      events_seen++;
      pay_len = 0; type_len = 0; got_data = 0;
      return;
    end
    if (line_buf[0] == sse_pkg::CH_COLON) return;
    line_len = len;
    if (line_has("data:")) begin
      off = 5;
      if (off < len && line_buf[off] == sse_pkg::CH_SPACE) off++;
      if (pay_len < CAP) begin
        if (got_data) add_payload(sse_pkg::CH_LF);
        for (int unsigned i = off; i < len; i++) add_payload(line_buf[i]);
      end else ovf = 1;
      got_data = 1;
    end else if (line_has("event:")) begin
      off = 6;
      if (off < len && line_buf[off] == sse_pkg::CH_SPACE) off++;
      type_len = 0;
      for (int unsigned i = off; i < len && type_len < CAP; i++) begin
        type_buf[type_len] = line_buf[i];
        type_len++;
      end
    end
  endfunction

  // accepted input word
  function void note_byte(byte unsigned b);
    if (b == sse_pkg::CH_LF) begin
      end_line();
      line_len = 0;
    end else if (line_len < CAP) begin
      line_buf[line_len] = b;
      line_len++;
    end else ovf = 1;
  endfunction

  // accepted output word
  function void check_chunk(chunk_t got);
    chunk_t exp;
    chunks_seen++;
    if (pending.size() == 0) begin
      $error("unexpected chunk %h", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.part !== exp.part) begin
      $error("part exp %0d got %0d", exp.part, got.part); errors++;
    end
    if (got.packed_bytes !== exp.packed_bytes) begin
      $error("packed_bytes exp %h got %h", exp.packed_bytes, got.packed_bytes); errors++;
    end
    if (got.byte_count !== exp.byte_count) begin
      $error("byte_count exp %0d got %0d", exp.byte_count, got.byte_count); errors++;
    end
    if (got.last_of_part !== exp.last_of_part) begin
      $error("last_of_part exp %0d got %0d", exp.last_of_part, got.last_of_part);
      errors++;
    end
    if (got.last_of_event !== exp.last_of_event) begin
      $error("last_of_event exp %0d got %0d", exp.last_of_event, got.last_of_event);
      errors++;
    end
    if (got.overflow_seen !== exp.overflow_seen) begin
      $error("overflow_seen exp %0d got %0d", exp.overflow_seen, got.overflow_seen);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import sse_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_part;
  logic [63:0] out_packed_bytes;
  logic [3:0]  out_byte_count;
  logic        out_last_of_part;
  logic        out_last_of_event;
  logic        out_overflow_seen;

  sse_event_parser_core #(.FIELD_CAP(64)) uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_byte_in,
    .out_valid, .out_stall, .out_part, .out_packed_bytes, .out_byte_count,
    .out_last_of_part, .out_last_of_event, .out_overflow_seen
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  chunk_scoreboard sb = new();

  // bytes waiting to go out, in stream order
  byte unsigned stream[$];
  int           idle_cycles = 0;
  int           bytes_sent = 0;
  int           burst_left = 0;
  bit           sender_on = 1'b0;

  // sender: bursts of random length with random gaps; payload held while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_byte(in_byte_in);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (sender_on && stream.size() > 0 && burst_left > 0) begin
          in_valid <= 1'b1;
          in_byte_in <= stream.pop_front();
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (burst_left == 0)
            burst_left = ($urandom_range(0, 3) == 0) ? -$urandom_range(1, 6)
                                                       : $urandom_range(1, 40);
          else if (burst_left < 0) burst_left++;
        end
      end
    end
  end

  // receiver: own stall pattern, switching at random between calm and choppy stretches
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_chunk({out_part, out_packed_bytes, out_byte_count,
                        out_last_of_part, out_last_of_event, out_overflow_seen});
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  task automatic add_line(string s);
    add_text(s);
    stream.push_back(CH_LF);
  endtask

  task automatic add_rand_bytes(int n, bit any_byte);
    byte unsigned b;
    for (int i = 0; i < n; i++) begin
      b = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7E));
      if (b == CH_LF) b = 8'h00;
      stream.push_back(b);
    end
  endtask

  // an event of random lines (data, event, comment or noise) ended by a blank line
  task automatic add_rand_event();
    int kind;
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        if ($urandom_range(0, 1)) add_text("data: ");
        else add_text("data:");
        add_rand_bytes(($urandom_range(0, 9) == 0) ? $urandom_range(50, 75)
                                                    : $urandom_range(0, 20),
                       $urandom_range(0, 3) == 0);
      end else if (kind < 7) begin
        if ($urandom_range(0, 1)) add_text("event: ");
        else add_text("event:");
        add_rand_bytes($urandom_range(0, 20), $urandom_range(0, 3) == 0);
      end else if (kind == 7) begin
        add_text(":"); add_rand_bytes($urandom_range(0, 10), 1'b0);
      end else if (kind == 8) begin
        add_text("dat"); add_rand_bytes($urandom_range(0, 10), 1'b1);
      end else begin
        add_rand_bytes($urandom_range(0, 12), 1'b1);
      end
      if ($urandom_range(0, 3) == 0) stream.push_back(CH_CR);
      stream.push_back(CH_LF);
    end
    if ($urandom_range(0, 3) == 0) stream.push_back(CH_CR);
    stream.push_back(CH_LF);
  endtask

  task automatic wait_drained();
    while (stream.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: comment, plain data, event with CR, empty dispatch
    add_line(": hi");
    add_line("data: A");
    add_text("event:x"); stream.push_back(CH_CR); stream.push_back(CH_LF);
    add_line("");
    add_line("");
    // empty type and empty data strings, all-ones and NUL bytes
    add_line("data:");
    stream.push_back(CH_CR); stream.push_back(CH_LF);
    stream.push_back(8'hFF); stream.push_back(8'h00); stream.push_back(CH_LF);
    sender_on = 1'b1;
    wait_drained();
    // pause until every chunk is back
    sender_on = 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    sender_on = 1'b1;

    // long line overflow, then payload past the cap
    add_text("data: "); add_rand_bytes(70, 1'b1); stream.push_back(CH_LF);
    add_text("data:"); add_rand_bytes(40, 1'b0); stream.push_back(CH_LF);
    add_line("data:z");
    add_text("event: "); add_rand_bytes(20, 1'b0); stream.push_back(CH_LF);
    add_line("");

    // random part: mostly events, some noise
    while (stream.size() + bytes_sent < 230) begin
      if ($urandom_range(0, 9) == 0) begin
        add_rand_bytes($urandom_range(1, 20), 1'b1);
        stream.push_back(CH_LF);
      end else add_rand_event();
      if (stream.size() > 200) wait_drained();
    end
    wait_drained();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d stream bytes, %0d events, %0d chunks checked.",
             bytes_sent, sb.events_seen, sb.chunks_seen);
    $display("Included comments, CR stripping, long lines, payload overflow.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sse_pkg.sv
hw/rtl/sse_mem.sv
hw/rtl/sse_event_parser_core.sv
tb/tb_top.sv
